### hw/rtl/joint_keyframe_interpolator_defines.svh
// Assertion helpers for the checker file of this block.
`ifndef JOINT_KEYFRAME_INTERPOLATOR_DEFINES_SVH
`define JOINT_KEYFRAME_INTERPOLATOR_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define JKI_ASSERT_NOW(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define JKI_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/jki_pkg.sv
package jki_pkg;

  localparam int ANGLE_W = 16;
  localparam int IDX_W   = 5;
  localparam int REQ_W   = 2;
  localparam int STEP_W  = 4;
  // Magnitude of a blended sum plus the rounding half fits in this many bits.
  localparam int MAG_W   = 20;

  localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TICK = 2'd1;
  localparam logic [REQ_W-1:0] REQ_HOME = 2'd2;

  localparam logic KIND_CMD  = 1'b0;
  localparam logic KIND_DROP = 1'b1;

  typedef struct packed {
    logic                      go;
    logic signed [ANGLE_W-1:0] start_val;
    logic signed [ANGLE_W-1:0] target_val;
    logic        [STEP_W-1:0]  step;
  } blend_req_t;

endpackage

### hw/rtl/joint_keyframe_interpolator.sv
// Joint keyframe interpolator.
// Input channel (in_valid / in_stall): one item is a request. A push stores
// joint_value into the staging pose and, with end_of_pose set, commits the
// staging pose into the pose queue; a home write sets one joint of the target
// pose; a tick produces one row of joint commands, unless it finds the queue
// empty at a segment start. in_stall is high while the block works on an
// item; push without mark and home writes leave it low.
// Output channel (out_valid / out_stall): one item is a result. A tick that
// runs gives JOINTS commands, joint 0 first, last_of_run on the final one; a
// commit into a full queue gives one drop item. The output register keeps its
// item while out_stall is high, and the sequencer waits in its emit or drop
// step until it frees.
// A commit writes one queue entry per cycle, joint by joint. A tick runs each
// joint through the shared blend unit in its sum, reciprocal multiply and emit
// steps, the emit step loading the command into the output register; at a
// segment start it first loads the next pose from the queue, read then write.
// Reset clears the staging, start and target poses, the queue pointers, the
// fill count, the step and the output valid flag; the queue memory needs no
// clearing pass, since only committed entries are ever read.
module joint_keyframe_interpolator #(
  parameter int JOINTS            = 18,
  parameter int STEPS_PER_SEGMENT = 10,
  parameter int QUEUE_DEPTH       = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [jki_pkg::REQ_W-1:0]          req_type,
  input  logic [jki_pkg::IDX_W-1:0]          joint_index,
  input  logic signed [jki_pkg::ANGLE_W-1:0] joint_value,
  input  logic                               end_of_pose,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               result_kind,
  output logic [jki_pkg::IDX_W-1:0]          joint_number,
  output logic signed [jki_pkg::ANGLE_W-1:0] command_value,
  output logic                               last_of_run
);

  localparam int JW        = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int MEM_DEPTH = QUEUE_DEPTH * JOINTS;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int FW        = $clog2(QUEUE_DEPTH + 1);
  localparam int SW        = jki_pkg::STEP_W;
  localparam logic [JW-1:0] LAST_J    = JW'(JOINTS - 1);
  localparam logic [AW-1:0] LAST_BASE = AW'(MEM_DEPTH - JOINTS);
  localparam logic [AW-1:0] ROW       = AW'(JOINTS);
  localparam logic [FW-1:0] FULL      = FW'(QUEUE_DEPTH);
  localparam logic [SW-1:0] LAST_STEP = SW'(STEPS_PER_SEGMENT - 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_COMMIT  = 3'd1;
  localparam logic [2:0] S_LOAD_RD = 3'd2;
  localparam logic [2:0] S_LOAD_WR = 3'd3;
  localparam logic [2:0] S_CALC    = 3'd4;
  localparam logic [2:0] S_MULW    = 3'd5;
  localparam logic [2:0] S_EMIT    = 3'd6;
  localparam logic [2:0] S_DROP    = 3'd7;

  logic [2:0]    state;
  logic [JW-1:0] jc;
  logic [AW-1:0] head_base;
  logic [AW-1:0] tail_base;
  logic [FW-1:0] fill;
  logic [SW-1:0] step_index;

  logic signed [jki_pkg::ANGLE_W-1:0] pose_staging [JOINTS];
  logic signed [jki_pkg::ANGLE_W-1:0] start_pose   [JOINTS];
  logic signed [jki_pkg::ANGLE_W-1:0] target_pose  [JOINTS];

  logic                               accept;
  logic                               idx_ok;
  logic                               out_free;
  logic                               mem_we;
  logic                               mem_re;
  logic [AW-1:0]                      mem_waddr;
  logic [AW-1:0]                      mem_raddr;
  logic signed [jki_pkg::ANGLE_W-1:0] mem_rdata;
  logic signed [jki_pkg::ANGLE_W-1:0] blend_out;
  jki_pkg::blend_req_t                blend_req;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  // An index outside the pose stores nothing.
  assign idx_ok   = ({1'b0, joint_index} < 6'(JOINTS));
  assign out_free = !out_valid || !out_stall;

  assign mem_we    = (state == S_COMMIT);
  assign mem_re    = (state == S_LOAD_RD);
  assign mem_waddr = tail_base + AW'(jc);
  assign mem_raddr = head_base + AW'(jc);

  always_comb begin
    blend_req.go         = (state == S_CALC);
    blend_req.start_val  = start_pose[jc];
    blend_req.target_val = target_pose[jc];
    blend_req.step       = step_index;
  end

  jki_pose_ram #(
    .DEPTH(MEM_DEPTH)
  ) u_pose_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(pose_staging[jc]),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  jki_blend #(
    .STEPS_PER_SEGMENT(STEPS_PER_SEGMENT)
  ) u_blend (
    .clk   (clk),
    .req   (blend_req),
    .result(blend_out)
  );

  // Sequencer, pose registers and queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      jc         <= '0;
      head_base  <= '0;
      tail_base  <= '0;
      fill       <= '0;
      step_index <= '0;
      for (int i = 0; i < JOINTS; i++) begin
        pose_staging[i] <= '0;
        start_pose[i]   <= '0;
        target_pose[i]  <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            jc <= '0;
            case (req_type)
              jki_pkg::REQ_PUSH: begin
                if (idx_ok) begin
                  pose_staging[joint_index[JW-1:0]] <= joint_value;
                end
                if (end_of_pose) begin
                  state <= (fill == FULL) ? S_DROP : S_COMMIT;
                end
              end
              jki_pkg::REQ_HOME: begin
                if (idx_ok) begin
                  target_pose[joint_index[JW-1:0]] <= joint_value;
                end
              end
              jki_pkg::REQ_TICK: begin
                // A tick with an empty queue at the start of a segment is idle.
                if (step_index == '0) begin
                  if (fill != '0) begin
                    for (int i = 0; i < JOINTS; i++) begin
                      start_pose[i] <= target_pose[i];
                    end
                    state <= S_LOAD_RD;
                  end
                end else begin
                  state <= S_CALC;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_COMMIT: begin
          if (jc == LAST_J) begin
            tail_base <= (tail_base == LAST_BASE) ? '0 : tail_base + ROW;
            fill      <= fill + FW'(1);
            state     <= S_IDLE;
          end else begin
            jc <= jc + JW'(1);
          end
        end
        S_LOAD_RD: begin
          state <= S_LOAD_WR;
        end
        S_LOAD_WR: begin
          target_pose[jc] <= mem_rdata;
          if (jc == LAST_J) begin
            head_base <= (head_base == LAST_BASE) ? '0 : head_base + ROW;
            fill      <= fill - FW'(1);
            jc        <= '0;
            state     <= S_CALC;
          end else begin
            jc    <= jc + JW'(1);
            state <= S_LOAD_RD;
          end
        end
        S_CALC: begin
          state <= S_MULW;
        end
        S_MULW: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            if (jc == LAST_J) begin
              step_index <= (step_index == LAST_STEP) ? '0 : step_index + SW'(1);
              state      <= S_IDLE;
            end else begin
              jc    <= jc + JW'(1);
              state <= S_CALC;
            end
          end
        end
        S_DROP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: holds its item until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_EMIT || state == S_DROP) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (state == S_EMIT) begin
        result_kind   <= jki_pkg::KIND_CMD;
        joint_number  <= jki_pkg::IDX_W'(jc);
        command_value <= blend_out;
        last_of_run   <= (jc == LAST_J);
      end else if (state == S_DROP) begin
        result_kind   <= jki_pkg::KIND_DROP;
        joint_number  <= '0;
        command_value <= '0;
        last_of_run   <= 1'b1;
      end
    end
  end

endmodule

### hw/rtl/jki_pose_ram.sv
module jki_pose_ram #(
  parameter int DEPTH = 1152
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [$clog2(DEPTH)-1:0]           waddr,
  input  logic signed [jki_pkg::ANGLE_W-1:0] wdata,
  input  logic                               re,
  input  logic [$clog2(DEPTH)-1:0]           raddr,
  output logic signed [jki_pkg::ANGLE_W-1:0] rdata
);

  logic signed [jki_pkg::ANGLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/jki_blend.sv
module jki_blend #(
  parameter int STEPS_PER_SEGMENT = 10
) (
  input  logic                               clk,
  input  jki_pkg::blend_req_t                req,
  output logic signed [jki_pkg::ANGLE_W-1:0] result
);

  localparam int MAG_W = jki_pkg::MAG_W;
  localparam int SH    = MAG_W + $clog2(STEPS_PER_SEGMENT);
  localparam int RW    = SH + 1;
  localparam int PW    = MAG_W + RW;
  localparam int QW    = jki_pkg::ANGLE_W + 1;
  localparam longint RECIP_L =
    ((longint'(1) << SH) + STEPS_PER_SEGMENT - 1) / STEPS_PER_SEGMENT;
  localparam logic [RW-1:0] RECIP = RW'(RECIP_L);
  localparam logic [MAG_W-1:0] HALF = MAG_W'(STEPS_PER_SEGMENT / 2);

  logic [jki_pkg::STEP_W-1:0] w_start;
  logic signed [MAG_W-1:0]    s_ext;
  logic signed [MAG_W-1:0]    t_ext;
  logic signed [MAG_W-1:0]    ws_ext;
  logic signed [MAG_W-1:0]    wt_ext;
  logic signed [MAG_W-1:0]    sum;
  logic [MAG_W-1:0]           mag_next;
  logic                       neg;
  logic                       neg_d;
  logic [MAG_W-1:0]           mag;
  logic [PW-1:0]              prod;
  logic [QW-1:0]              quot;
  logic [QW-1:0]              value;

  // Weighted sum of the two poses, then magnitude with the rounding half added.
  always_comb begin
    w_start  = jki_pkg::STEP_W'(STEPS_PER_SEGMENT) - req.step;
    s_ext    = MAG_W'(req.start_val);
    t_ext    = MAG_W'(req.target_val);
    ws_ext   = MAG_W'($signed({1'b0, w_start}));
    wt_ext   = MAG_W'($signed({1'b0, req.step}));
    sum      = s_ext * ws_ext + t_ext * wt_ext;
    mag_next = (sum[MAG_W-1] ? MAG_W'(-sum) : MAG_W'(sum)) + HALF;
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      neg <= sum[MAG_W-1];
      mag <= mag_next;
    end
    // Division by the step count as a multiply by its rounded-up reciprocal.
    prod  <= PW'(mag) * PW'(RECIP);
    neg_d <= neg;
  end

  always_comb begin
    quot   = prod[SH +: QW];
    value  = neg_d ? QW'(-quot) : quot;
    result = value[jki_pkg::ANGLE_W-1:0];
  end

endmodule

### hw/rtl/jki_checker.sv
`include "joint_keyframe_interpolator_defines.svh"

module jki_checker #(
  parameter int JOINTS = 18
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic                               result_kind,
  input logic [jki_pkg::IDX_W-1:0]          joint_number,
  input logic signed [jki_pkg::ANGLE_W-1:0] command_value,
  input logic                               last_of_run
);

  // A stalled result item stays on the port unchanged.
  `JKI_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(result_kind) && $stable(joint_number) && $stable(command_value) && $stable(last_of_run), "stalled output item changed")

  // A drop item is a single, empty item.
  `JKI_ASSERT_NOW(a_drop_form, clk, rst, out_valid && result_kind == jki_pkg::KIND_DROP, last_of_run && joint_number == '0 && command_value == '0, "malformed drop item")

  // Commands address a real joint, and only the final joint closes the run.
  `JKI_ASSERT_NOW(a_cmd_last, clk, rst, out_valid && result_kind == jki_pkg::KIND_CMD, ({1'b0, joint_number} < 6'(JOINTS)) && (last_of_run == (joint_number == 5'(JOINTS - 1))), "command joint or last mark wrong")

  // Reset empties the output register.
  `JKI_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid, "output valid after reset")

endmodule

bind joint_keyframe_interpolator jki_checker #(.JOINTS(JOINTS)) u_jki_checker (.*);
